### design/assert_macros.svh
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/sha1_pkg.sv
package sha1_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;

  localparam int NUM_H = 5;

  localparam word_t H_INIT [0:NUM_H-1] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_CH  = 32'h5A827999;
  localparam word_t K_P1  = 32'h6ED9EBA1;
  localparam word_t K_MAJ = 32'h8F1BBCDC;
  localparam word_t K_P2  = 32'hCA62C1D6;

  localparam logic [6:0] CH_END     = 7'd20;
  localparam logic [6:0] P1_END     = 7'd40;
  localparam logic [6:0] MAJ_END    = 7'd60;
  localparam logic [6:0] LOAD_END   = 7'd16;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  localparam byte_t PAD_MARK = 8'h80;

  // Word slots of the length field, and the last slot that still leaves it room.
  localparam logic [3:0] LEN_HI_IDX   = 4'd14;
  localparam logic [3:0] LEN_LO_IDX   = 4'd15;
  localparam logic [3:0] LAST_MARK_OK = 4'd13;

  function automatic word_t round_k(logic [6:0] t);
    word_t k;
    if (t < CH_END) begin
      k = K_CH;
    end else if (t < P1_END) begin
      k = K_P1;
    end else if (t < MAJ_END) begin
      k = K_MAJ;
    end else begin
      k = K_P2;
    end
    return k;
  endfunction

  function automatic word_t round_f(logic [6:0] t, word_t b, word_t c, word_t d);
    word_t f;
    if (t < CH_END) begin
      f = (b & c) | (~b & d);
    end else if (t >= P1_END && t < MAJ_END) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

### design/sha1_if.sv
interface sha1_in_if;
  logic                valid;
  logic                ready;
  sha1_pkg::byte_t     data_byte;
  logic                has_byte;
  logic                end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic                valid;
  logic                ready;
  sha1_pkg::word_t     digest_word;
  logic                last_word;
  logic                length_error;

  modport source (output valid, output digest_word, output last_word,
                  output length_error, input ready);
  modport sink   (input valid, input digest_word, input last_word,
                  input length_error, output ready);
endinterface

### design/sha1_stream_hasher.sv
// Channel   Direction  Word                                        Flow
// msg       in         data_byte, has_byte, end_of_message         valid/ready
// digest    out        digest_word, last_word, length_error        valid/ready
//
// A byte that neither fills a block nor ends the message leaves the input ready.
// A byte that completes a block is followed by a read setup, 80 rounds and one hash update.
// Without overflow, a final word adds up to 18 padding writes and one or two compressions.
// One round runs per cycle; two copies of the schedule memory serve its four reads.
// Reset is synchronous; the hash restarts from the initial values after each digest.
// Five digest words follow; a stalled one holds, and no byte is taken until the fifth leaves.
module sha1_stream_hasher (
  input  logic       clk,
  input  logic       rst,
  sha1_in_if.sink    msg,
  sha1_out_if.source digest
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_ROUND, S_FINAL, S_PAD, S_OUT} state_t;

  state_t      state;
  logic [6:0]  round;
  logic [5:0]  fill;
  logic [23:0] acc;
  logic [63:0] bit_count;
  logic        ovf;
  logic        msg_end;
  logic        pad_started;
  logic        len_blk;
  logic        final_blk;
  logic [3:0]  pad_idx;
  logic [2:0]  out_idx;
  word_t       h [0:NUM_H-1];
  word_t       wa, wb, wc, wd, we;

  // Two copies of the block buffer / schedule ring give four reads per round.
  word_t       mem_a [0:15];
  word_t       mem_b [0:15];
  word_t       rd_a0, rd_a1, rd_b0, rd_b1;
  logic [3:0]  rd_t;

  logic        accept, take_byte, count_full, store_byte, ovf_set, block_full;
  logic [5:0]  fill_next;
  word_t       byte_word, mark_word, pad_word, w_exp, w_t, tmp;
  logic        wr_en;
  logic [3:0]  wr_addr;
  word_t       wr_data;

  assign msg.ready  = (state == S_IDLE);
  assign accept     = msg.valid && msg.ready;
  assign take_byte  = accept && msg.has_byte && !ovf;
  assign count_full = &bit_count[63:3];
  assign store_byte = take_byte && !count_full;
  assign ovf_set    = take_byte && count_full;
  assign fill_next  = store_byte ? fill + 6'd1 : fill;
  assign block_full = store_byte && (fill == 6'd63);
  assign byte_word  = {acc, msg.data_byte};

  always_comb begin
    case (fill[1:0])
      2'd0:    mark_word = {PAD_MARK, 24'h0};
      2'd1:    mark_word = {acc[7:0], PAD_MARK, 16'h0};
      2'd2:    mark_word = {acc[15:0], PAD_MARK, 8'h0};
      default: mark_word = {acc[23:0], PAD_MARK};
    endcase
  end

  always_comb begin
    if (!pad_started) begin
      pad_word = mark_word;
    end else if (len_blk && pad_idx == LEN_HI_IDX) begin
      pad_word = bit_count[63:32];
    end else if (len_blk && pad_idx == LEN_LO_IDX) begin
      pad_word = bit_count[31:0];
    end else begin
      pad_word = '0;
    end
  end

  assign w_exp = {rd_a0[30:0] ^ rd_a1[30:0] ^ rd_b0[30:0] ^ rd_b1[30:0],
                  rd_a0[31] ^ rd_a1[31] ^ rd_b0[31] ^ rd_b1[31]};
  assign w_t   = (round < LOAD_END) ? rd_b1 : w_exp;
  assign tmp   = {wa[26:0], wa[31:27]} + round_f(round, wb, wc, wd) + we + w_t
               + round_k(round);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[5:2];
    wr_data = byte_word;
    case (state)
      S_IDLE: begin
        wr_en = store_byte && (fill[1:0] == 2'd3);
      end
      S_ROUND: begin
        wr_en   = (round >= LOAD_END);
        wr_addr = round[3:0];
        wr_data = w_exp;
      end
      S_PAD: begin
        wr_en   = 1'b1;
        wr_addr = pad_idx;
        wr_data = pad_word;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Reads for round t+1 go out while round t runs; none of them hits slot t.
  assign rd_t = (state == S_ROUND) ? round[3:0] + 4'd1 : 4'd0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    rd_a0 <= mem_a[rd_t - 4'd3];
    rd_a1 <= mem_a[rd_t - 4'd8];
    rd_b0 <= mem_b[rd_t - 4'd14];
    rd_b1 <= mem_b[rd_t];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && store_byte) begin
      acc <= {acc[15:0], msg.data_byte};
    end
    if (state == S_PREP) begin
      wa <= h[0];
      wb <= h[1];
      wc <= h[2];
      wd <= h[3];
      we <= h[4];
    end else if (state == S_ROUND) begin
      we <= wd;
      wd <= wc;
      wc <= {wb[1:0], wb[31:2]};
      wb <= wa;
      wa <= tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      round       <= '0;
      fill        <= '0;
      bit_count   <= '0;
      ovf         <= 1'b0;
      msg_end     <= 1'b0;
      pad_started <= 1'b0;
      len_blk     <= 1'b0;
      final_blk   <= 1'b0;
      pad_idx     <= '0;
      out_idx     <= '0;
      h           <= H_INIT;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (store_byte) begin
              bit_count <= bit_count + 64'd8;
              fill      <= fill_next;
            end
            if (ovf_set) begin
              ovf <= 1'b1;
            end
            if (msg.end_of_message) begin
              msg_end     <= 1'b1;
              pad_started <= 1'b0;
            end
            if (block_full) begin
              final_blk <= 1'b0;
              state     <= S_PREP;
            end else if (msg.end_of_message) begin
              if (ovf || ovf_set) begin
                out_idx <= '0;
                state   <= S_OUT;
              end else begin
                pad_idx <= fill_next[5:2];
                len_blk <= (fill_next[5:2] <= LAST_MARK_OK);
                state   <= S_PAD;
              end
            end
          end
        end
        S_PREP: begin
          round <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          round <= round + 7'd1;
          if (round == LAST_ROUND) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          h[0] <= h[0] + wa;
          h[1] <= h[1] + wb;
          h[2] <= h[2] + wc;
          h[3] <= h[3] + wd;
          h[4] <= h[4] + we;
          if (!msg_end) begin
            state <= S_IDLE;
          end else if (final_blk) begin
            out_idx <= '0;
            state   <= S_OUT;
          end else begin
            pad_idx <= '0;
            len_blk <= 1'b1;
            state   <= S_PAD;
          end
        end
        S_PAD: begin
          pad_started <= 1'b1;
          pad_idx     <= pad_idx + 4'd1;
          if (pad_idx == LEN_LO_IDX) begin
            final_blk <= len_blk;
            state     <= S_PREP;
          end
        end
        S_OUT: begin
          if (digest.ready) begin
            out_idx <= out_idx + 3'd1;
            for (int i = 0; i < NUM_H - 1; i++) begin
              h[i] <= h[i + 1];
            end
            h[NUM_H - 1] <= h[0];
            if (out_idx == 3'(NUM_H - 1)) begin
              h         <= H_INIT;
              bit_count <= '0;
              ovf       <= 1'b0;
              fill      <= '0;
              msg_end   <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign digest.valid        = (state == S_OUT);
  assign digest.digest_word  = ovf ? '0 : h[0];
  assign digest.last_word    = (out_idx == 3'(NUM_H - 1));
  assign digest.length_error = ovf;

endmodule

### design/sha1_checker.sv
`include "assert_macros.svh"

module sha1_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_end,
  input logic            out_valid,
  input logic            out_ready,
  input sha1_pkg::word_t out_word,
  input logic            out_last,
  input logic            out_error
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // No byte is taken while digest words are pending.
  `CHK_SAME(a_no_input_during_output, clk, rst, out_valid, !in_ready)
  // The final word of a message always starts work that blocks input.
  `CHK_NEXT(a_end_blocks_input, clk, rst, in_acc && in_end, !in_ready)
  // The digest stream ends right after its last word.
  `CHK_NEXT(a_last_ends_stream, clk, rst, out_acc && out_last, !out_valid)
  // A flagged digest carries no hash bits.
  `CHK_SAME(a_error_zero_word, clk, rst, out_valid && out_error, out_word == '0)
  // A stalled digest word holds.
  `CHK_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready,
            out_valid && $stable(out_word))

endmodule

bind sha1_stream_hasher sha1_checker u_sha1_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (msg.valid),
  .in_ready  (msg.ready),
  .in_end    (msg.end_of_message),
  .out_valid (digest.valid),
  .out_ready (digest.ready),
  .out_word  (digest.digest_word),
  .out_last  (digest.last_word),
  .out_error (digest.length_error)
);
